// ===== rtl/ipf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the IP allow/deny prefix filter.
// No dependencies; ipf_ctrl, ipf_dp and the top level in rtl/ import this package.
package ipf_pkg;

  // Default list depth.
  localparam int MAX_ENTRIES_DEF = 16;

  // Field widths.
  localparam int ADDR_W  = 64;
  localparam int PFX_W   = 8;
  localparam int ATTR_W  = PFX_W + 1;
  localparam int ENTRY_W = 2 * ADDR_W + ATTR_W;

  // Prefix limits per family.
  localparam logic [PFX_W-1:0] PFX_MAX_V4 = 8'd32;
  localparam logic [PFX_W-1:0] PFX_MAX_V6 = 8'd128;

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ALLOW = 2'd1,
    OP_DENY  = 2'd2,
    OP_QUERY = 2'd3
  } ipf_op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_PREFIX = 2'd2,
    ST_MCAST  = 2'd3
  } ipf_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2,
    S_DONE = 2'd3
  } ipf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted input word
    logic exec;       // run clear/add, reset scan state
    logic scan_step;  // issue one list read and fold in the last one
    logic out_load;   // move the result into the output register
  } ipf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic scan_more;
  } ipf_stat_t;

endpackage

// ===== rtl/ipf_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ipf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the IP prefix filter: handshakes and sequencing.
// Depends on ipf_pkg.
module ipf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ipf_pkg::ipf_stat_t stat,
  output ipf_pkg::ipf_cmd_t  cmd
);

  import ipf_pkg::*;

  ipf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.is_query ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        // The cycle with nothing left to issue folds in the final read.
        cmd.scan_step = 1'b1;
        if (!stat.scan_more) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/ipf_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the IP prefix filter: word capture, list RAMs, counts, matching
// and the output register. Depends on ipf_pkg and ipf_ram.
module ipf_dp #(
  parameter int MAX_ENTRIES = ipf_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ipf_pkg::ipf_cmd_t         cmd,
  output ipf_pkg::ipf_stat_t        stat,
  input  logic [1:0]                in_opcode,
  input  logic                      in_is_v6,
  input  logic [ipf_pkg::ADDR_W-1:0] in_addr_hi,
  input  logic [ipf_pkg::ADDR_W-1:0] in_addr_lo,
  input  logic [ipf_pkg::PFX_W-1:0]  in_prefix_len,
  output logic                      out_allowed,
  output logic                      out_allow_hit,
  output logic                      out_deny_hit,
  output logic [1:0]                out_status
);

  import ipf_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  // Captured input word.
  ipf_op_t           op_r;
  logic              v6_r;
  logic [ADDR_W-1:0] hi_r, lo_r;
  logic [PFX_W-1:0]  pfx_r;

  // List state.
  logic [CNT_W-1:0]  allow_cnt_r, allow_cnt_nxt;
  logic [CNT_W-1:0]  deny_cnt_r, deny_cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt, scan_len;
  logic              rd_vld_a_r, rd_vld_a_nxt, rd_vld_d_r, rd_vld_d_nxt;
  logic              issue;

  // Result registers.
  logic              ah_r, ah_nxt, dh_r, dh_nxt;
  ipf_status_t       st_r, st_nxt;
  logic              o_allowed_r, o_ah_r, o_dh_r;
  ipf_status_t       o_st_r;

  // RAM interface.
  logic               we_a, we_d;
  logic [CNT_W-1:0]   wcnt;
  logic [ENTRY_W-1:0] wdata, rdata_a, rdata_d;
  logic               hit_a, hit_d;
  logic               pfx_bad, mcast;

  // Entry match against the captured query address.
  function automatic logic entry_hit(input logic [ENTRY_W-1:0] ent, input logic q6,
                                     input logic [ADDR_W-1:0] qhi,
                                     input logic [ADDR_W-1:0] qlo);
    logic [ADDR_W-1:0] ehi, elo, mh, ml;
    logic [31:0]       m4;
    logic              e6;
    logic [PFX_W-1:0]  p;
    logic              res;
    ehi = ent[ENTRY_W-1 -: ADDR_W];
    elo = ent[ATTR_W +: ADDR_W];
    e6  = ent[PFX_W];
    p   = ent[PFX_W-1:0];
    m4  = ~(32'hFFFF_FFFF >> p);
    mh  = ~({ADDR_W{1'b1}} >> p);
    ml  = (p > 8'd64) ? ~({ADDR_W{1'b1}} >> (p - 8'd64)) : '0;
    if (p == '0) begin
      // Zero IPv4 entry with exact prefix is a wildcard for both families.
      res = (!e6 && elo == '0) || (e6 == q6 && ehi == qhi && elo == qlo);
    end else if (e6 != q6) begin
      res = 1'b0;
    end else if (!e6) begin
      res = ((elo[31:0] ^ qlo[31:0]) & m4) == '0;
    end else begin
      res = (((ehi ^ qhi) & mh) == '0) && (((elo ^ qlo) & ml) == '0);
    end
    return res;
  endfunction

  // Capture the word; IPv4 keeps only the low 32 address bits.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= ipf_op_t'(in_opcode);
      v6_r  <= in_is_v6;
      hi_r  <= in_is_v6 ? in_addr_hi : '0;
      lo_r  <= in_is_v6 ? in_addr_lo : {32'd0, in_addr_lo[31:0]};
      pfx_r <= in_prefix_len;
    end
  end

  // Add checks.
  assign pfx_bad = pfx_r > (v6_r ? PFX_MAX_V6 : PFX_MAX_V4);
  assign mcast   = v6_r ? (hi_r[63:56] == 8'hFF) : (lo_r[31:28] == 4'hE);
  assign wdata   = {hi_r, lo_r, v6_r, pfx_r};

  // Scan bookkeeping: walk up to the longer list, one entry per cycle.
  assign scan_len       = (allow_cnt_r > deny_cnt_r) ? allow_cnt_r : deny_cnt_r;
  assign stat.scan_more = idx_r < scan_len;
  assign stat.is_query  = op_r == OP_QUERY;
  assign issue          = cmd.scan_step && stat.scan_more;

  assign hit_a = rd_vld_a_r && entry_hit(rdata_a, v6_r, hi_r, lo_r);
  assign hit_d = rd_vld_d_r && entry_hit(rdata_d, v6_r, hi_r, lo_r);

  // Execute, scan and accumulate.
  always_comb begin
    allow_cnt_nxt = allow_cnt_r;
    deny_cnt_nxt  = deny_cnt_r;
    idx_nxt       = idx_r;
    ah_nxt        = ah_r | hit_a;
    dh_nxt        = dh_r | hit_d;
    st_nxt        = st_r;
    we_a          = 1'b0;
    we_d          = 1'b0;
    wcnt          = (op_r == OP_ALLOW) ? allow_cnt_r : deny_cnt_r;
    rd_vld_a_nxt  = issue && (idx_r < allow_cnt_r);
    rd_vld_d_nxt  = issue && (idx_r < deny_cnt_r);
    if (issue) begin
      idx_nxt = CNT_W'(idx_r + 1'b1);
    end
    if (cmd.exec) begin
      idx_nxt = '0;
      ah_nxt  = 1'b0;
      dh_nxt  = 1'b0;
      st_nxt  = ST_OK;
      unique case (op_r)
        OP_CLEAR: begin
          allow_cnt_nxt = '0;
          deny_cnt_nxt  = '0;
        end
        OP_ALLOW, OP_DENY: begin
          if (pfx_bad) begin
            st_nxt = ST_PREFIX;
          end else if (mcast) begin
            st_nxt = ST_MCAST;
          end else if (wcnt >= CNT_MAX) begin
            st_nxt = ST_FULL;
          end else if (op_r == OP_ALLOW) begin
            we_a          = 1'b1;
            allow_cnt_nxt = CNT_W'(allow_cnt_r + 1'b1);
          end else begin
            we_d         = 1'b1;
            deny_cnt_nxt = CNT_W'(deny_cnt_r + 1'b1);
          end
        end
        OP_QUERY: begin
          st_nxt = ST_OK;
        end
        default: st_nxt = ST_OK;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_cnt_r <= '0;
      deny_cnt_r  <= '0;
      idx_r       <= '0;
      rd_vld_a_r  <= 1'b0;
      rd_vld_d_r  <= 1'b0;
    end else begin
      allow_cnt_r <= allow_cnt_nxt;
      deny_cnt_r  <= deny_cnt_nxt;
      idx_r       <= idx_nxt;
      rd_vld_a_r  <= rd_vld_a_nxt;
      rd_vld_d_r  <= rd_vld_d_nxt;
    end
  end

  // Result accumulators and output register.
  always_ff @(posedge clk) begin
    ah_r <= ah_nxt;
    dh_r <= dh_nxt;
    st_r <= st_nxt;
    if (cmd.out_load) begin
      o_allowed_r <= ah_r && !dh_r;
      o_ah_r      <= ah_r;
      o_dh_r      <= dh_r;
      o_st_r      <= st_r;
    end
  end

  // Allow and deny list storage.
  ipf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_allow_ram (
    .clk  (clk),
    .we   (we_a),
    .waddr(wcnt[IDX_W-1:0]),
    .wdata(wdata),
    .raddr(idx_r[IDX_W-1:0]),
    .rdata(rdata_a)
  );

  ipf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_deny_ram (
    .clk  (clk),
    .we   (we_d),
    .waddr(wcnt[IDX_W-1:0]),
    .wdata(wdata),
    .raddr(idx_r[IDX_W-1:0]),
    .rdata(rdata_d)
  );

  assign out_allowed   = o_allowed_r;
  assign out_allow_hit = o_ah_r;
  assign out_deny_hit  = o_dh_r;
  assign out_status    = o_st_r;

endmodule

// ===== rtl/ip_allow_deny_prefix_filter_core.sv =====
`timescale 1ns / 1ps
// IPv4/IPv6 allow/deny prefix filter, top level.
// Depends on ipf_pkg, ipf_ctrl, ipf_dp and ipf_ram.
//
// The filter holds an allow list and a deny list of up to MAX_ENTRIES entries
// each, in two RAMs with one read port apiece. Words are taken one at a time.
// A clear or add word is executed once accepted; a query then reads both lists
// in parallel, one entry of each per cycle, up to the longer list's count. Each
// result waits in the done state until the output register is free. The result
// sits in an output register, and the next word is accepted while it waits to be
// taken.
module ip_allow_deny_prefix_filter_core #(
  parameter int MAX_ENTRIES = ipf_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic                       in_is_v6,
  input  logic [ipf_pkg::ADDR_W-1:0] in_addr_hi,
  input  logic [ipf_pkg::ADDR_W-1:0] in_addr_lo,
  input  logic [ipf_pkg::PFX_W-1:0]  in_prefix_len,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_allowed,
  output logic                       out_allow_hit,
  output logic                       out_deny_hit,
  output logic [1:0]                 out_status
);

  import ipf_pkg::*;

  ipf_cmd_t  cmd;
  ipf_stat_t stat;

  // Sequencing and handshakes.
  ipf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Lists, matching and result register.
  ipf_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_opcode    (in_opcode),
    .in_is_v6     (in_is_v6),
    .in_addr_hi   (in_addr_hi),
    .in_addr_lo   (in_addr_lo),
    .in_prefix_len(in_prefix_len),
    .out_allowed  (out_allowed),
    .out_allow_hit(out_allow_hit),
    .out_deny_hit (out_deny_hit),
    .out_status   (out_status)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ip_allow_deny_prefix_filter_core: drives clear, add and
// query words, predicts every verdict with an in-bench access-list model and checks it.
// Depends on rtl/ipf_pkg.sv and the filter RTL under rtl/.
module tb_top;
  import ipf_pkg::*;

  localparam int LIST_DEPTH     = MAX_ENTRIES_DEF;
  localparam int LIST_ALLOW     = 0;
  localparam int LIST_DENY      = 1;
  localparam int ITEM_TARGET    = 1600;
  localparam int MAX_GAP        = 11;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = LIST_DEPTH + 24;
  localparam int MAX_REPORTS    = 60;

  // One verdict of the filter, as it appears on the result port.
  typedef struct packed {
    logic        allowed;
    logic        allow_hit;
    logic        deny_hit;
    ipf_status_t status;
  } verdict_t;

  // Entry used by the stimulus to derive queries that land near stored prefixes.
  typedef struct {
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  pfx;
  } rule_t;

  // Access-list model: keeps both lists and the verdicts still owed by the block.
  class acl_scoreboard;
    logic [63:0] ent_hi  [2][LIST_DEPTH];
    logic [63:0] ent_lo  [2][LIST_DEPTH];
    logic        ent_v6  [2][LIST_DEPTH];
    logic [7:0]  ent_pfx [2][LIST_DEPTH];
    int          count   [2];
    verdict_t    verdicts_due[$];
    int          errors;
    int          reports;

    function new();
      count[LIST_ALLOW] = 0;
      count[LIST_DENY]  = 0;
      errors  = 0;
      reports = 0;
    endfunction

    // Prefix 0 is an exact match; an all-zero IPv4 exact entry matches anything.
    function bit entry_matches(int lst, int idx, logic q6, logic [63:0] qhi,
                               logic [63:0] qlo);
      int          p;
      logic [31:0] m4;
      logic [63:0] mh;
      logic [63:0] ml;
      p = int'(ent_pfx[lst][idx]);
      if (p == 0) begin
        if (!ent_v6[lst][idx] && ent_lo[lst][idx] == 64'd0) return 1'b1;
        return ent_v6[lst][idx] == q6 && ent_hi[lst][idx] == qhi && ent_lo[lst][idx] == qlo;
      end
      if (ent_v6[lst][idx] != q6) return 1'b0;
      if (!q6) begin
        m4 = 32'hFFFF_FFFF << (32 - p);
        return (ent_lo[lst][idx][31:0] & m4) == (qlo[31:0] & m4);
      end
      mh = (p >= 64) ? ~64'd0 : (~64'd0 << (64 - p));
      ml = (p <= 64) ? 64'd0 : (~64'd0 << (128 - p));
      return ((ent_hi[lst][idx] ^ qhi) & mh) == 64'd0 &&
             ((ent_lo[lst][idx] ^ qlo) & ml) == 64'd0;
    endfunction

    // Apply one accepted word to the lists and queue the verdict it must give.
    function void note_word(ipf_op_t op, logic v6, logic [63:0] hi_in,
                            logic [63:0] lo_in, logic [7:0] pfx);
      verdict_t    v;
      logic [63:0] hi;
      logic [63:0] lo;
      int          lst;
      bit          mcast;
      v  = '0;
      hi = v6 ? hi_in : 64'd0;
      lo = v6 ? lo_in : {32'd0, lo_in[31:0]};
      case (op)
        OP_CLEAR: begin
          count[LIST_ALLOW] = 0;
          count[LIST_DENY]  = 0;
        end
        OP_QUERY: begin
          for (int i = 0; i < count[LIST_ALLOW]; i++)
            if (entry_matches(LIST_ALLOW, i, v6, hi, lo)) v.allow_hit = 1'b1;
          for (int i = 0; i < count[LIST_DENY]; i++)
            if (entry_matches(LIST_DENY, i, v6, hi, lo)) v.deny_hit = 1'b1;
          v.allowed = v.allow_hit && !v.deny_hit;
        end
        default: begin
          lst   = (op == OP_ALLOW) ? LIST_ALLOW : LIST_DENY;
          mcast = v6 ? (hi[63:56] == 8'hFF) : (lo[31:28] == 4'hE);
          if (pfx > (v6 ? PFX_MAX_V6 : PFX_MAX_V4)) begin
            v.status = ST_PREFIX;
          end else if (mcast) begin
            v.status = ST_MCAST;
          end else if (count[lst] >= LIST_DEPTH) begin
            v.status = ST_FULL;
          end else begin
            ent_hi[lst][count[lst]]  = hi;
            ent_lo[lst][count[lst]]  = lo;
            ent_v6[lst][count[lst]]  = v6;
            ent_pfx[lst][count[lst]] = pfx;
            count[lst]++;
          end
        end
      endcase
      verdicts_due = {verdicts_due, v};
    endfunction

    function void report_field(string name, int exp_val, int act_val);
      errors++;
      if (reports < MAX_REPORTS)
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name,
                 exp_val, act_val);
      else if (reports == MAX_REPORTS)
        $display("%0t: further mismatches are not shown", $time);
      reports++;
    endfunction

    // Compare one accepted verdict with the oldest one owed.
    function void check_verdict(verdict_t act);
      verdict_t exp_v;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, act);
        return;
      end
      exp_v = verdicts_due.pop_front();
      if (act.allowed !== exp_v.allowed)
        report_field("allowed", exp_v.allowed, act.allowed);
      if (act.allow_hit !== exp_v.allow_hit)
        report_field("allow_hit", exp_v.allow_hit, act.allow_hit);
      if (act.deny_hit !== exp_v.deny_hit)
        report_field("deny_hit", exp_v.deny_hit, act.deny_hit);
      if (act.status !== exp_v.status)
        report_field("status", exp_v.status, act.status);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic        in_is_v6;
  logic [63:0] in_addr_hi;
  logic [63:0] in_addr_lo;
  logic [7:0]  in_prefix_len;
  logic        out_valid;
  logic        out_ready;
  logic        out_allowed;
  logic        out_allow_hit;
  logic        out_deny_hit;
  logic [1:0]  out_status;

  acl_scoreboard sb;
  rule_t         rule_pool[$];
  int            words_sent;
  bit            tx_idle_en;
  bit            rx_idle_en;
  int            rx_hold_len;

  ip_allow_deny_prefix_filter_core #(
    .MAX_ENTRIES(LIST_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_is_v6(in_is_v6),
    .in_addr_hi(in_addr_hi),
    .in_addr_lo(in_addr_lo),
    .in_prefix_len(in_prefix_len),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_allowed(out_allowed),
    .out_allow_hit(out_allow_hit),
    .out_deny_hit(out_deny_hit),
    .out_status(out_status)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitors: every accepted input word feeds the model, every result word is checked.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_word(ipf_op_t'(in_opcode), in_is_v6, in_addr_hi, in_addr_lo, in_prefix_len);
    if (rst_n && out_valid && out_ready)
      sb.check_verdict({out_allowed, out_allow_hit, out_deny_hit, ipf_status_t'(out_status)});
  end

  // Result side: random stalls per word, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        stall       = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(MAX_GAP, 0) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Watchdog: ends the run when nothing moves on either port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one word after a random gap and wait until the filter takes it.
  task automatic send_word(ipf_op_t op, logic v6, logic [63:0] hi, logic [63:0] lo,
                           logic [7:0] pfx);
    int gap;
    gap = tx_idle_en ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_is_v6      <= v6;
    in_addr_hi    <= hi;
    in_addr_lo    <= lo;
    in_prefix_len <= pfx;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Add one random rule, mostly well formed, and remember it for later queries.
  task automatic add_rule(ipf_op_t op);
    rule_t r;
    r.v6 = 1'($urandom_range(1, 0));
    r.hi = rand64();
    r.lo = rand64();
    case ($urandom_range(19, 0))
      0, 1: r.pfx = 8'($urandom_range(255, r.v6 ? 129 : 33));
      2, 3: r.pfx = 8'd0;
      4: begin
        // IPv4 wildcard, with junk in the ignored upper bits
        r.v6  = 1'b0;
        r.lo  = {$urandom, 32'd0};
        r.pfx = 8'd0;
      end
      5: begin
        // Multicast address with a legal prefix
        if (r.v6) r.hi[63:56] = 8'hFF;
        else r.lo[31:28] = 4'hE;
        r.pfx = 8'($urandom_range(r.v6 ? 128 : 32, 0));
      end
      default: r.pfx = 8'($urandom_range(r.v6 ? 128 : 32, 1));
    endcase
    send_word(op, r.v6, r.hi, r.lo, r.pfx);
    rule_pool = {rule_pool, r};
  endtask

  // Query near a stored rule: exact, a bit flipped inside or outside its prefix,
  // or the other family; sometimes, or with no rules stored, a fully random query.
  task automatic query_near_rule();
    rule_t        r;
    logic [127:0] a;
    int           w;
    int           p;
    int           k;
    if (rule_pool.size() == 0 || $urandom_range(5, 0) == 0) begin
      send_word(OP_QUERY, 1'($urandom_range(1, 0)), rand64(), rand64(),
                8'($urandom_range(255, 0)));
      return;
    end
    r = rule_pool[$urandom_range(rule_pool.size() - 1, 0)];
    a = {r.hi, r.lo};
    w = r.v6 ? 128 : 32;
    p = (r.pfx > w) ? w : r.pfx;
    case ($urandom_range(3, 0))
      1: begin
        k = $urandom_range(((p == 0) ? w : p) - 1, 0);
        a[w - 1 - k] = ~a[w - 1 - k];
      end
      2: begin
        if (p != 0 && p < w) begin
          k = $urandom_range(w - 1, p);
          a[w - 1 - k] = ~a[w - 1 - k];
        end
      end
      3: r.v6 = ~r.v6;
      default: ;
    endcase
    if (!r.v6) a[63:32] = $urandom;
    send_word(OP_QUERY, r.v6, a[127:64], a[63:0], 8'($urandom_range(255, 0)));
  endtask

  // A policy: optional clear, a batch of rules, then queries around them.
  task automatic run_policy();
    int n_rules;
    int n_queries;
    if ($urandom_range(3, 0) == 0) begin
      send_word(OP_CLEAR, 1'($urandom_range(1, 0)), rand64(), rand64(),
                8'($urandom_range(255, 0)));
      rule_pool.delete();
    end
    n_rules   = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 12) : $urandom_range(6, 1);
    n_queries = $urandom_range(12, 3);
    for (int i = 0; i < n_rules; i++)
      add_rule(($urandom_range(1, 0) == 0) ? OP_ALLOW : OP_DENY);
    for (int i = 0; i < n_queries; i++)
      query_near_rule();
  endtask

  // Noise: fully random words of any kind.
  task automatic run_noise();
    int n;
    ipf_op_t op;
    n = $urandom_range(8, 2);
    for (int i = 0; i < n; i++) begin
      op = ipf_op_t'($urandom_range(3, 0));
      if (op == OP_CLEAR) rule_pool.delete();
      send_word(op, 1'($urandom_range(1, 0)), rand64(), rand64(),
                8'($urandom_range(255, 0)));
    end
  endtask

  // Main sequence: reset, directed words, random policies, drain, verdict.
  initial begin : main_flow
    bit pressure_done;
    sb            = new();
    words_sent    = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    rx_hold_len   = 0;
    pressure_done = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_CLEAR;
    in_is_v6      <= 1'b0;
    in_addr_hi    <= 64'd0;
    in_addr_lo    <= 64'd0;
    in_prefix_len <= 8'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty lists, for both families.
    send_word(OP_QUERY, 1'b0, 64'd0, 64'd0, 8'd0);
    send_word(OP_QUERY, 1'b1, ~64'd0, ~64'd0, 8'd255);
    // Prefix out of range is checked before multicast.
    send_word(OP_ALLOW, 1'b0, 64'd0, 64'h0000_0000_0A00_0000, 8'd33);
    send_word(OP_ALLOW, 1'b1, 64'h2001_0DB8_0000_0000, 64'd1, 8'd129);
    send_word(OP_DENY, 1'b0, 64'd0, 64'h0000_0000_E000_0001, 8'd255);
    // Multicast rejects at both ends of the IPv4 range and for IPv6.
    send_word(OP_ALLOW, 1'b0, 64'd0, 64'h0000_0000_E000_0001, 8'd8);
    send_word(OP_DENY, 1'b0, 64'd0, 64'h0000_0000_EFFF_FFFF, 8'd32);
    send_word(OP_ALLOW, 1'b1, 64'hFF02_0000_0000_0000, 64'd1, 8'd16);
    // IPv4 wildcard with junk in the ignored bits, then an IPv6 exact deny.
    send_word(OP_ALLOW, 1'b0, ~64'd0, 64'hFFFF_FFFF_0000_0000, 8'd0);
    send_word(OP_QUERY, 1'b1, 64'h2001_0DB8_0000_0001, 64'h0000_0000_0000_00AB, 8'd7);
    send_word(OP_DENY, 1'b1, 64'h2001_0DB8_0000_0001, 64'h0000_0000_0000_00AB, 8'd0);
    send_word(OP_QUERY, 1'b1, 64'h2001_0DB8_0000_0001, 64'h0000_0000_0000_00AB, 8'd0);
    send_word(OP_QUERY, 1'b1, 64'h2001_0DB8_0000_0001, 64'h0000_0000_0000_00AA, 8'd0);
    // IPv4 /8 deny, hit from IPv4 and missed from IPv6 with the same low bits.
    send_word(OP_DENY, 1'b0, 64'd0, 64'h0000_0000_0A00_0000, 8'd8);
    send_word(OP_QUERY, 1'b0, 64'h1234_5678_9ABC_DEF0, 64'hDEAD_BEEF_0A01_0203, 8'd0);
    send_word(OP_QUERY, 1'b1, 64'd0, 64'h0000_0000_0A01_0203, 8'd0);
    // Clear with every field set.
    send_word(OP_CLEAR, 1'b1, ~64'd0, ~64'd0, 8'hFF);
    // Longest and shortest prefixes of both families.
    send_word(OP_ALLOW, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, ~64'd0, 8'd128);
    send_word(OP_ALLOW, 1'b1, 64'h2001_0DB8_0000_0000, 64'd0, 8'd1);
    send_word(OP_ALLOW, 1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF, 8'd32);
    send_word(OP_DENY, 1'b0, 64'd0, 64'h0000_0000_8000_0000, 8'd1);
    send_word(OP_QUERY, 1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF, 8'd0);
    send_word(OP_QUERY, 1'b1, 64'h3000_0000_0000_0000, 64'd0, 8'd0);
    send_word(OP_QUERY, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, ~64'd0, 8'd0);
    send_word(OP_QUERY, 1'b0, 64'd0, 64'd0, 8'd0);

    // Random part: mostly coherent policies, some noise, idling switched per batch.
    while (words_sent < ITEM_TARGET) begin
      tx_idle_en = ($urandom_range(3, 0) != 0);
      rx_idle_en = ($urandom_range(3, 0) != 0);
      if (!pressure_done && words_sent >= 400) begin
        // Receiver holds off while words keep coming back to back.
        pressure_done = 1'b1;
        rx_hold_len   = HOLD_CYCLES;
        tx_idle_en    = 1'b0;
        for (int i = 0; i < 20; i++) query_near_rule();
      end else if ($urandom_range(9, 0) < 7) begin
        run_policy();
      end else begin
        run_noise();
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed verdict, then watch for stray results.
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
